FILE: sv/bc_pkg.sv
// shared constants, codes and helpers for the barometric compensation pipeline
package bc_pkg;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int ADC_W       = 20;
    localparam int DIV_W       = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_COEFFS       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_COEFFS_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_COEFFS_HIGH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_COEFF_LAST  = 2'd3;

    localparam logic [63:0] T_FINE_OFFSET = 64'd128000;
    localparam logic [63:0] PRESS_BASE    = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE   = 64'd3125;
    localparam logic [63:0] P1_BIAS       = 64'h0000_8000_0000_0000;
    localparam logic [31:0] TEMP_ROUND    = 32'd128;

    typedef logic [63:0] word64_t;

    function automatic word64_t sext16(input logic [15:0] x);
        sext16 = {{48{x[15]}}, x};
    endfunction

endpackage

FILE: sv/bc_mul64.sv
// pipelined 64x64 multipliers keeping the low 64 product bits, two stages
module bc_mul64 #(
    parameter int NMUL = 1,
    parameter int SW   = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [NMUL-1:0][63:0]      a,
    input  logic [NMUL-1:0][63:0]      b,
    input  logic [SW-1:0]              side_in,
    output logic                       out_valid,
    output logic [NMUL-1:0][63:0]      p,
    output logic [SW-1:0]              side_out
);

    logic [NMUL-1:0][63:0] ll_reg;
    logic [NMUL-1:0][31:0] lh_reg;
    logic [NMUL-1:0][31:0] hl_reg;
    logic [SW-1:0]         side1_reg;
    logic                  valid1_reg;
    logic [NMUL-1:0][63:0] p_reg;
    logic [SW-1:0]         side2_reg;
    logic                  valid2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NMUL; i++) begin
                ll_reg[i] <= 64'(a[i][31:0]) * 64'(b[i][31:0]);
                lh_reg[i] <= 32'(a[i][31:0] * b[i][63:32]);
                hl_reg[i] <= 32'(a[i][63:32] * b[i][31:0]);
                p_reg[i]  <= ll_reg[i] + {32'(lh_reg[i] + hl_reg[i]), 32'd0};
            end
            side1_reg <= side_in;
            side2_reg <= side1_reg;
        end
    end

    assign out_valid = valid2_reg;
    assign p         = p_reg;
    assign side_out  = side2_reg;

endmodule

FILE: sv/bc_sdiv.sv
// pipelined signed 64-bit divider, one quotient bit per stage, truncating
module bc_sdiv #(
    parameter int SW = 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [bc_pkg::DIV_W-1:0] dividend,
    input  logic [bc_pkg::DIV_W-1:0] divisor,
    input  logic [SW-1:0]          side_in,
    output logic                   out_valid,
    output logic [bc_pkg::DIV_W-1:0] quotient,
    output logic [SW-1:0]          side_out
);

    localparam int W = bc_pkg::DIV_W;

    logic [W-1:0]  r_reg     [W+1];
    logic [W-1:0]  nq_reg    [W+1];
    logic [W-1:0]  d_reg     [W+1];
    logic          neg_reg   [W+1];
    logic [SW-1:0] side_reg  [W+1];
    logic [W:0]    valid_reg;
    logic [W-1:0]  q_reg;
    logic [SW-1:0] qside_reg;
    logic          qvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            qvalid_reg <= 1'b0;
        end else if (en) begin
            valid_reg  <= {valid_reg[W-1:0], in_valid};
            qvalid_reg <= valid_reg[W];
        end
    end

    // sign and magnitude stage
    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]    <= '0;
            nq_reg[0]   <= dividend[W-1] ? W'(0) - dividend : dividend;
            d_reg[0]    <= divisor[W-1] ? W'(0) - divisor : divisor;
            neg_reg[0]  <= dividend[W-1] ^ divisor[W-1];
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 0; k < W; k++) begin : g_step
        logic [W-1:0] r_sh;
        logic         ge;
        always_comb begin
            r_sh = {r_reg[k][W-2:0], nq_reg[k][W-1]};
            ge   = (r_sh >= d_reg[k]);
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k+1]    <= ge ? r_sh - d_reg[k] : r_sh;
                nq_reg[k+1]   <= {nq_reg[k][W-2:0], ge};
                d_reg[k+1]    <= d_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg     <= neg_reg[W] ? W'(0) - nq_reg[W] : nq_reg[W];
            qside_reg <= side_reg[W];
        end
    end

    assign out_valid = qvalid_reg;
    assign quotient  = q_reg;
    assign side_out  = qside_reg;

endmodule

FILE: sv/bc_temp.sv
// four-stage fine-temperature pipeline with a carried side payload
module bc_temp #(
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [19:0]   adc_t,
    input  logic [SW-1:0] side_in,
    input  logic [47:0]   coeffs,
    output logic          out_valid,
    output logic [31:0]   tfine,
    output logic [SW-1:0] side_out
);

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;

    logic [31:0]   a_reg, b_reg;
    logic [31:0]   m1_reg, bb_reg;
    logic [31:0]   tv1_reg, m2_reg;
    logic [31:0]   tfine_reg;
    logic [SW-1:0] side_reg [4];
    logic [3:0]    valid_reg;

    logic [31:0] tv1_c, bbs_c, m2s_c;

    assign t1 = {16'd0, coeffs[15:0]};
    assign t2 = {{16{coeffs[31]}}, coeffs[31:16]};
    assign t3 = {{16{coeffs[47]}}, coeffs[47:32]};

    always_comb begin
        tv1_c = $signed(m1_reg) >>> 11;
        bbs_c = $signed(bb_reg) >>> 12;
        m2s_c = $signed(m2_reg) >>> 14;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg       <= 32'(adc_t >> 3) - (t1 << 1);
            b_reg       <= 32'(adc_t >> 4) - t1;
            m1_reg      <= 32'(a_reg * t2);
            bb_reg      <= 32'(b_reg * b_reg);
            tv1_reg     <= tv1_c;
            m2_reg      <= 32'(bbs_c * t3);
            tfine_reg   <= tv1_reg + m2s_c;
            side_reg[0] <= side_in;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side_reg[1];
            side_reg[3] <= side_reg[2];
        end
    end

    assign out_valid = valid_reg[3];
    assign tfine     = tfine_reg;
    assign side_out  = side_reg[3];

endmodule

FILE: sv/barometric_compensation_top.sv
// barometric compensation: one result transfer for each input transfer
// throughput one item per cycle while the output is not stalled; the 64-stage divider sets most of the latency
// one enable moves every stage, so a stalled output holds the whole pipeline
// synchronous active-low reset clears all valid bits and the calibration registers
module barometric_compensation_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // temperature_centi[31:0], pressure_q24_8[63:32],
                                   // divide_by_zero[64], zero fill[71:65]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_last_reg;

    logic en;

    logic [63:0] p1c, p2c, p3c, p4c, p5c, p6c, p7c, p8c, p9c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_coeffs_reg <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
            press_last_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bc_pkg::REG_TEMP_COEFFS:       temp_coeffs_reg <= cfg_wdata[47:0];
                bc_pkg::REG_PRESS_COEFFS_LOW:  press_low_reg   <= cfg_wdata;
                bc_pkg::REG_PRESS_COEFFS_HIGH: press_high_reg  <= cfg_wdata;
                bc_pkg::REG_PRESS_COEFF_LAST:  press_last_reg  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign p1c = {48'd0, press_low_reg[15:0]};
    assign p2c = bc_pkg::sext16(press_low_reg[31:16]);
    assign p3c = bc_pkg::sext16(press_low_reg[47:32]);
    assign p4c = bc_pkg::sext16(press_low_reg[63:48]);
    assign p5c = bc_pkg::sext16(press_high_reg[15:0]);
    assign p6c = bc_pkg::sext16(press_high_reg[31:16]);
    assign p7c = bc_pkg::sext16(press_high_reg[47:32]);
    assign p8c = bc_pkg::sext16(press_high_reg[63:48]);
    assign p9c = bc_pkg::sext16(press_last_reg);

    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // fine temperature
    logic        t_valid;
    logic [31:0] t_fine;
    logic [19:0] t_adcp;

    bc_temp #(.SW(20)) u_temp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .adc_t     (s_tdata[19:0]),
        .side_in   (s_tdata[39:20]),
        .coeffs    (temp_coeffs_reg),
        .out_valid (t_valid),
        .tfine     (t_fine),
        .side_out  (t_adcp)
    );

    // offset fine temperature and centidegree result
    logic [31:0] tc_sum_c, temp_c;
    logic [63:0] v1_reg;
    logic [31:0] st1_temp_reg;
    logic [19:0] st1_adcp_reg;
    logic        st1_valid_reg;

    always_comb begin
        tc_sum_c = 32'(t_fine * 32'd5) + bc_pkg::TEMP_ROUND;
        temp_c   = $signed(tc_sum_c) >>> 8;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v1_reg       <= {{32{t_fine[31]}}, t_fine} - bc_pkg::T_FINE_OFFSET;
            st1_temp_reg <= temp_c;
            st1_adcp_reg <= t_adcp;
        end
    end

    // square and linear terms
    logic [2:0][63:0] m1_a, m1_b, m1_p;
    logic [51:0]      m1_side;
    logic             m1_valid;

    assign m1_a[0] = v1_reg;
    assign m1_b[0] = v1_reg;
    assign m1_a[1] = v1_reg;
    assign m1_b[1] = p5c;
    assign m1_a[2] = v1_reg;
    assign m1_b[2] = p2c;

    bc_mul64 #(.NMUL(3), .SW(52)) u_mul_sq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (st1_valid_reg),
        .a         (m1_a),
        .b         (m1_b),
        .side_in   ({st1_temp_reg, st1_adcp_reg}),
        .out_valid (m1_valid),
        .p         (m1_p),
        .side_out  (m1_side)
    );

    logic [1:0][63:0] m2_a, m2_b, m2_p;
    logic [179:0]     m2_side;
    logic             m2_valid;

    assign m2_a[0] = m1_p[0];
    assign m2_b[0] = p6c;
    assign m2_a[1] = m1_p[0];
    assign m2_b[1] = p3c;

    bc_mul64 #(.NMUL(2), .SW(180)) u_mul_quad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (m1_valid),
        .a         (m2_a),
        .b         (m2_b),
        .side_in   ({m1_p[1], m1_p[2], m1_side}),
        .out_valid (m2_valid),
        .p         (m2_p),
        .side_out  (m2_side)
    );

    // collect v2 and the p1 scale term
    logic [63:0] y3s_c;
    logic [63:0] v2_reg, v1b_reg, pd_reg;
    logic [31:0] st2_temp_reg;
    logic        st2_valid_reg;

    assign y3s_c = $signed(m2_p[1]) >>> 8;

    always_ff @(posedge aclk) begin
        if (en) begin
            v2_reg       <= m2_p[0] + (m2_side[179:116] << 17) + (p4c << 35);
            v1b_reg      <= y3s_c + (m2_side[115:52] << 12);
            pd_reg       <= bc_pkg::PRESS_BASE - {44'd0, m2_side[19:0]};
            st2_temp_reg <= m2_side[51:20];
        end
    end

    logic [63:0] s47_reg, nd_reg;
    logic [31:0] st3_temp_reg;
    logic        st3_valid_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s47_reg      <= bc_pkg::P1_BIAS + v1b_reg;
            nd_reg       <= (pd_reg << 31) - v2_reg;
            st3_temp_reg <= st2_temp_reg;
        end
    end

    logic [1:0][63:0] m3_a, m3_b, m3_p;
    logic [31:0]      m3_side;
    logic             m3_valid;

    assign m3_a[0] = s47_reg;
    assign m3_b[0] = p1c;
    assign m3_a[1] = nd_reg;
    assign m3_b[1] = bc_pkg::PRESS_SCALE;

    bc_mul64 #(.NMUL(2), .SW(32)) u_mul_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (st3_valid_reg),
        .a         (m3_a),
        .b         (m3_b),
        .side_in   (st3_temp_reg),
        .out_valid (m3_valid),
        .p         (m3_p),
        .side_out  (m3_side)
    );

    // divisor and zero check
    logic [63:0] den_c;
    logic [63:0] den_reg, num_reg;
    logic [31:0] st4_temp_reg;
    logic        st4_dz_reg;
    logic        st4_valid_reg;

    assign den_c = $signed(m3_p[0]) >>> 33;

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg      <= den_c;
            num_reg      <= m3_p[1];
            st4_temp_reg <= m3_side;
            st4_dz_reg   <= (den_c == 64'd0);
        end
    end

    logic        dv_valid;
    logic [63:0] dv_q;
    logic [32:0] dv_side;

    bc_sdiv #(.SW(33)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (st4_valid_reg),
        .dividend  (num_reg),
        .divisor   (den_reg),
        .side_in   ({st4_temp_reg, st4_dz_reg}),
        .out_valid (dv_valid),
        .quotient  (dv_q),
        .side_out  (dv_side)
    );

    // second-order pressure correction
    logic [63:0] ps_c;
    logic [63:0] q1_p_reg, q1_ps_reg;
    logic [32:0] q1_side_reg;
    logic        q1_valid_reg;

    assign ps_c = $signed(dv_q) >>> 13;

    always_ff @(posedge aclk) begin
        if (en) begin
            q1_p_reg    <= dv_q;
            q1_ps_reg   <= ps_c;
            q1_side_reg <= dv_side;
        end
    end

    logic [1:0][63:0] m4_a, m4_b, m4_p;
    logic [160:0]     m4_side;
    logic             m4_valid;

    assign m4_a[0] = q1_ps_reg;
    assign m4_b[0] = p9c;
    assign m4_a[1] = p8c;
    assign m4_b[1] = q1_p_reg;

    bc_mul64 #(.NMUL(2), .SW(161)) u_mul_corr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q1_valid_reg),
        .a         (m4_a),
        .b         (m4_b),
        .side_in   ({q1_p_reg, q1_ps_reg, q1_side_reg}),
        .out_valid (m4_valid),
        .p         (m4_p),
        .side_out  (m4_side)
    );

    logic [0:0][63:0] m5_a, m5_b, m5_p;
    logic [160:0]     m5_side;
    logic             m5_valid;

    assign m5_a[0] = m4_p[0];
    assign m5_b[0] = m4_side[96:33];

    bc_mul64 #(.NMUL(1), .SW(161)) u_mul_sq2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (m4_valid),
        .a         (m5_a),
        .b         (m5_b),
        .side_in   ({m4_side[160:97], m4_p[1], m4_side[32:0]}),
        .out_valid (m5_valid),
        .p         (m5_p),
        .side_out  (m5_side)
    );

    logic [63:0] w1_c, w2_c;
    logic [63:0] sum_reg;
    logic [32:0] q2_side_reg;
    logic        q2_valid_reg;

    always_comb begin
        w1_c = $signed(m5_p[0]) >>> 25;
        w2_c = $signed(m5_side[96:33]) >>> 19;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg     <= m5_side[160:97] + w1_c + w2_c;
            q2_side_reg <= m5_side[32:0];
        end
    end

    logic [63:0] sums_c;
    logic [63:0] pr_reg;
    logic [32:0] q3_side_reg;
    logic        q3_valid_reg;

    assign sums_c = $signed(sum_reg) >>> 8;

    always_ff @(posedge aclk) begin
        if (en) begin
            pr_reg      <= sums_c + (p7c << 4);
            q3_side_reg <= q2_side_reg;
        end
    end

    // saturation and output register
    logic [31:0] pres_c;

    always_comb begin
        if (q3_side_reg[0] || pr_reg[63]) begin
            pres_c = '0;
        end else if (pr_reg[62:32] != '0) begin
            pres_c = '1;
        end else begin
            pres_c = pr_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {7'd0, q3_side_reg[0], pres_c, q3_side_reg[32:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            q1_valid_reg  <= 1'b0;
            q2_valid_reg  <= 1'b0;
            q3_valid_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else if (en) begin
            st1_valid_reg <= t_valid;
            st2_valid_reg <= m2_valid;
            st3_valid_reg <= st2_valid_reg;
            st4_valid_reg <= m3_valid;
            q1_valid_reg  <= dv_valid;
            q2_valid_reg  <= m5_valid;
            q3_valid_reg  <= q2_valid_reg;
            m_tvalid_reg  <= q3_valid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_dz_zero_pressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[64] |-> m_tdata[63:32] == 32'd0)
        else $error("zero divisor result carries nonzero pressure");

    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[71:65] == 7'd0)
        else $error("fill bits of result not zero");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(m_tdata) && m_tvalid)
        else $error("pipeline moved while stalled");

endmodule

FILE: tb/tb_barometric_compensation_top.sv
// testbench for the barometric compensation pipeline: directed and random transfers
module tb_barometric_compensation_top;

    typedef struct packed {
        logic [31:0] temperature_centi;
        logic [31:0] pressure_q24_8;
        logic        divide_by_zero;
    } comp_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;

    logic [47:0] temp_coeffs_q;
    logic [63:0] press_low_q;
    logic [63:0] press_high_q;
    logic [15:0] press_last_q;

    comp_result_t expected_results[$];
    int  n_errors = 0;
    bit  src_idle_on = 1'b1;
    bit  snk_idle_on = 1'b1;
    bit  snk_hold = 1'b0;

    barometric_compensation_top u_top (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #40000000;
        $display("tb: failure");
        $finish;
    end

    function automatic comp_result_t compensate(input logic [19:0] adc_t,
                                                input logic [19:0] adc_p);
        comp_result_t r;
        logic signed [31:0] t1, t2, t3, a, b, tv1, tv2, tfine;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] v1, v2, p, ps, w1, w2, num;
        t1 = {16'd0, temp_coeffs_q[15:0]};
        t2 = {{16{temp_coeffs_q[31]}}, temp_coeffs_q[31:16]};
        t3 = {{16{temp_coeffs_q[47]}}, temp_coeffs_q[47:32]};
        p1 = {48'd0, press_low_q[15:0]};
        p2 = {{48{press_low_q[31]}}, press_low_q[31:16]};
        p3 = {{48{press_low_q[47]}}, press_low_q[47:32]};
        p4 = {{48{press_low_q[63]}}, press_low_q[63:48]};
        p5 = {{48{press_high_q[15]}}, press_high_q[15:0]};
        p6 = {{48{press_high_q[31]}}, press_high_q[31:16]};
        p7 = {{48{press_high_q[47]}}, press_high_q[47:32]};
        p8 = {{48{press_high_q[63]}}, press_high_q[63:48]};
        p9 = {{48{press_last_q[15]}}, press_last_q};
        a = $signed({12'd0, adc_t} >> 3) - (t1 <<< 1);
        tv1 = (a * t2) >>> 11;
        b = $signed({12'd0, adc_t} >> 4) - t1;
        tv2 = (((b * b) >>> 12) * t3) >>> 14;
        tfine = tv1 + tv2;
        r.temperature_centi = (tfine * 32'sd5 + 32'sd128) >>> 8;
        v1 = 64'(tfine) - 64'sd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
        r.pressure_q24_8 = '0;
        r.divide_by_zero = 1'b0;
        if (v1 == 0) begin
            r.divide_by_zero = 1'b1;
        end else begin
            p = 64'sd1048576 - $signed({44'd0, adc_p});
            num = ((p <<< 31) - v2) * 64'sd3125;
            if (v1 == -64'sd1) p = -num;
            else p = num / v1;
            ps = p >>> 13;
            w1 = (p9 * ps * ps) >>> 25;
            w2 = (p8 * p) >>> 19;
            p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
            if (p < 0) r.pressure_q24_8 = '0;
            else if (p > 64'sd4294967295) r.pressure_q24_8 = '1;
            else r.pressure_q24_8 = p[31:0];
        end
        return r;
    endfunction

    always @(negedge aclk) begin
        if (snk_hold) m_tready <= 1'b0;
        else m_tready <= !(snk_idle_on && $urandom_range(99) < 18);
    end

    always @(posedge aclk) begin
        comp_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[64]};
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer %h", m_tdata);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.temperature_centi !== want.temperature_centi) begin
                    $error("temperature_centi expected %h actual %h",
                           want.temperature_centi, got.temperature_centi);
                    n_errors++;
                end
                if (got.pressure_q24_8 !== want.pressure_q24_8) begin
                    $error("pressure_q24_8 expected %h actual %h",
                           want.pressure_q24_8, got.pressure_q24_8);
                    n_errors++;
                end
                if (got.divide_by_zero !== want.divide_by_zero) begin
                    $error("divide_by_zero expected %b actual %b",
                           want.divide_by_zero, got.divide_by_zero);
                    n_errors++;
                end
                if (m_tdata[71:65] !== '0) begin
                    $error("zero fill expected 0 actual %h", m_tdata[71:65]);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_sample(input logic [19:0] adc_t, input logic [19:0] adc_p);
        while (src_idle_on && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {adc_p, adc_t};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(compensate(adc_t, adc_p));
        @(negedge aclk);
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (100) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        case (idx)
            bc_pkg::REG_TEMP_COEFFS:       temp_coeffs_q = val[47:0];
            bc_pkg::REG_PRESS_COEFFS_LOW:  press_low_q = val;
            bc_pkg::REG_PRESS_COEFFS_HIGH: press_high_q = val;
            bc_pkg::REG_PRESS_COEFF_LAST:  press_last_q = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_calibration(input logic [47:0] t, input logic [63:0] pl,
                                    input logic [63:0] ph, input logic [15:0] p9);
        drain();
        write_reg(bc_pkg::REG_TEMP_COEFFS, {16'd0, t});
        write_reg(bc_pkg::REG_PRESS_COEFFS_LOW, pl);
        write_reg(bc_pkg::REG_PRESS_COEFFS_HIGH, ph);
        write_reg(bc_pkg::REG_PRESS_COEFF_LAST, {48'd0, p9});
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [63:0] rand64;
        return {$urandom, $urandom};
    endfunction

    // typical sensor calibration
    task automatic load_typical;
        load_calibration({16'hFC18, 16'd26435, 16'd27504},
                         {16'd2855, 16'hD508, 16'hF5E9, 16'd36477},
                         {16'hBBF2, 16'd15500, 16'hFFF9, 16'd140},
                         16'd6000);
    endtask

    task automatic test_reset_defaults;
        // all coefficients zero after reset: divisor is zero
        send_sample('0, '0);
        send_sample('1, '1);
    endtask

    task automatic test_directed;
        load_typical();
        send_sample(20'd519888, 20'd415148);
        send_sample('0, '0);
        send_sample('1, '1);
        send_sample('0, '1);
        send_sample('1, '0);
        send_sample(20'h55555, 20'hAAAAA);
        load_calibration('1, '1, '1, '1);
        send_sample('0, '0);
        send_sample('1, '1);
        send_sample(20'h80000, 20'h7FFFF);
        load_calibration({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                         {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF);
        send_sample('0, '0);
        send_sample('1, '1);
        load_calibration({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h8000, 16'h0001},
                         {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000);
        send_sample('0, '0);
        send_sample('1, '1);
        // p1 zero forces a zero divisor with live temperature
        load_calibration({16'hFC18, 16'd26435, 16'd27504}, 64'h1234_5678_9ABC_0000,
                         rand64(), 16'd6000);
        send_sample(20'd519888, 20'd415148);
        send_sample('1, '0);
    endtask

    task automatic test_backpressure;
        load_typical();
        fork
            begin
                snk_hold = 1'b1;
                repeat (300) @(negedge aclk);
                snk_hold = 1'b0;
            end
            repeat (200) send_sample(20'($urandom), 20'($urandom));
        join
    endtask

    task automatic test_random(input int n_sets);
        for (int s = 0; s < n_sets; s++) begin
            if (s % 3 == 0) load_typical();
            else if (s % 7 == 1)
                load_calibration(48'(rand64()), rand64(), rand64(), 16'($urandom));
            else
                load_calibration({16'($urandom_range(16'h3FFF, 16'h7FFF)), 16'($urandom),
                                  16'($urandom)},
                                 {48'(rand64()), 16'($urandom_range(1, 65535))},
                                 rand64(), 16'($urandom));
            src_idle_on = (s != 4);
            snk_idle_on = (s != 4);
            repeat (150) begin
                if ($urandom_range(9) < 8)
                    send_sample(20'($urandom_range(400000, 600000)),
                                20'($urandom_range(200000, 700000)));
                else
                    send_sample(20'($urandom), 20'($urandom));
            end
        end
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
    endtask

    initial begin
        temp_coeffs_q = '0;
        press_low_q = '0;
        press_high_q = '0;
        press_last_q = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_defaults();
        test_directed();
        test_backpressure();
        test_random(10);
        drain();
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
